[sv/idvn_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package idvn_pkg;

    // fixed formats
    localparam int COORD_FRAC  = 16;
    localparam int BLOCK_BITS  = 30;
    localparam int CONTRIB_EXP = COORD_FRAC + BLOCK_BITS;
    localparam int ACC_W       = 64;
    localparam int SQ_W        = 62;
    localparam int ROOT_W      = 31;
    localparam int OUT_W       = 32;
    localparam int CLZ_W       = 7;
    localparam int CNT_W       = 7;
    localparam int NORM_STEPS  = 6;
    localparam int QDEPTH      = 2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_NORM,
        S_SQ,
        S_SQRT,
        S_ROOT,
        S_DIV,
        S_DIV_DONE,
        S_LAST,
        S_EMIT
    } t_state;

    // which vector or quotient the shared units are working on
    typedef enum logic [1:0] {
        P_FACE,
        P_DIST,
        P_SUM,
        P_CONTRIB
    } t_phase;

    typedef struct packed {
        logic signed [OUT_W-1:0] z;
        logic signed [OUT_W-1:0] y;
        logic signed [OUT_W-1:0] x;
        logic                    degenerate;
    } t_result;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage
`default_nettype wire

[sv/inverse_distance_vertex_normal_core.sv]
// A face word with a zero area normal or zero distance only sets the degenerate flag;
// otherwise both vectors are normalized and rooted, and each component divided twice.
// A last word then normalizes, roots and divides the sum per component, unless flagged
// degenerate; the result is registered before tvalid. One quotient bit per cycle.
// No new word is taken until the last is through the shared root and divide units;
// a 2-word queue and an output register let input and output stall on their own.
// Synchronous active-low reset clears the accumulators, the flag and all handshakes.
`timescale 1ns / 1ps
`default_nettype none
module inverse_distance_vertex_normal_core #(
    parameter int COORD_WIDTH = 32,
    parameter int OUT_FRAC_BITS = 30,
    localparam int IN_W = ((9 * COORD_WIDTH + 7) / 8) * 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    // vertex_x, vertex_y, vertex_z, centroid_x, centroid_y, centroid_z,
    // area_normal_x, area_normal_y, area_normal_z
    input  wire logic [IN_W-1:0]    i_s_axis_tdata,
    input  wire logic               i_s_axis_tlast,
    output logic                    o_m_axis_tvalid,
    input  wire logic               i_m_axis_tready,
    // unit_normal_x, unit_normal_y, unit_normal_z
    output logic [95:0]             o_m_axis_tdata,
    // degenerate
    output logic                    o_m_axis_tuser
);

    localparam int MW = COORD_WIDTH + 1;
    localparam int ENTRY_W = 6 * MW + 6;

    logic                 q_push;
    logic                 q_pop;
    logic [ENTRY_W-1:0]   q_in;
    logic [ENTRY_W-1:0]   q_out;
    idvn_pkg::t_q_status  q_status;
    logic                 res_valid;
    logic                 res_ready;
    idvn_pkg::t_result    res;
    logic                 r_ovalid;
    idvn_pkg::t_result    r_odata;

    idvn_front #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_front (
        .i_valid    (i_s_axis_tvalid),
        .o_ready    (o_s_axis_tready),
        .i_data     (i_s_axis_tdata),
        .i_last     (i_s_axis_tlast),
        .i_q_status (q_status),
        .o_push     (q_push),
        .o_entry    (q_in)
    );

    idvn_queue #(
        .WIDTH(ENTRY_W)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_data   (q_in),
        .i_pop    (q_pop),
        .o_data   (q_out),
        .o_status (q_status)
    );

    idvn_back #(
        .COORD_WIDTH   (COORD_WIDTH),
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (!q_status.empty),
        .i_q_entry   (q_out),
        .o_q_pop     (q_pop),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    // output register
    assign res_ready = !r_ovalid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (res_ready) begin
            r_ovalid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_odata <= res;
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {r_odata.z, r_odata.y, r_odata.x};
    assign o_m_axis_tuser  = r_odata.degenerate;

`ifndef SYNTHESIS
    a_queue_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_status.full)
        else $error("queue written while full");

    a_queue_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_status.empty)
        else $error("queue read while empty");

    a_degenerate_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (o_m_axis_tdata == '0))
        else $error("degenerate result carries a nonzero normal");
`endif

endmodule
`default_nettype wire

[sv/idvn_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module idvn_front #(
    parameter int COORD_WIDTH = 32,
    localparam int MW = COORD_WIDTH + 1,
    localparam int ENTRY_W = 6 * MW + 6,
    localparam int IN_W = ((9 * COORD_WIDTH + 7) / 8) * 8
) (
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [IN_W-1:0]    i_data,
    input  wire logic               i_last,
    input  wire idvn_pkg::t_q_status i_q_status,
    output logic                    o_push,
    output logic [ENTRY_W-1:0]      o_entry
);

    logic [COORD_WIDTH-1:0] vtx [3];
    logic [COORD_WIDTH-1:0] cen [3];
    logic [COORD_WIDTH-1:0] nrm [3];
    logic [MW-1:0]          n_ext [3];
    logic [MW-1:0]          d_val [3];
    logic [2:0]             nneg;
    logic                   face_zero;
    logic                   dist_zero;

    assign o_ready = !i_q_status.full;
    assign o_push  = i_valid && o_ready;

    // unpack, form differences and magnitudes, classify zero vectors
    always_comb begin
        face_zero = 1'b1;
        dist_zero = 1'b1;
        o_entry   = '0;
        for (int i = 0; i < 3; i++) begin
            vtx[i]   = i_data[i * COORD_WIDTH +: COORD_WIDTH];
            cen[i]   = i_data[(3 + i) * COORD_WIDTH +: COORD_WIDTH];
            nrm[i]   = i_data[(6 + i) * COORD_WIDTH +: COORD_WIDTH];
            n_ext[i] = {nrm[i][COORD_WIDTH-1], nrm[i]};
            d_val[i] = {vtx[i][COORD_WIDTH-1], vtx[i]} - {cen[i][COORD_WIDTH-1], cen[i]};
            nneg[i]  = nrm[i][COORD_WIDTH-1];
            if (nrm[i] != '0) begin
                face_zero = 1'b0;
            end
            if (d_val[i] != '0) begin
                dist_zero = 1'b0;
            end
            o_entry[i * MW +: MW]       = nneg[i] ? (MW'(0) - n_ext[i]) : n_ext[i];
            o_entry[(3 + i) * MW +: MW] = d_val[i][MW-1] ? (MW'(0) - d_val[i]) : d_val[i];
        end
        o_entry[6 * MW +: 3] = nneg;
        o_entry[6 * MW + 3]  = i_last;
        o_entry[6 * MW + 4]  = face_zero;
        o_entry[6 * MW + 5]  = dist_zero;
    end

endmodule
`default_nettype wire

[sv/idvn_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
module idvn_queue #(
    parameter int WIDTH = 204
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire logic [WIDTH-1:0]   i_data,
    input  wire logic               i_pop,
    output logic [WIDTH-1:0]        o_data,
    output idvn_pkg::t_q_status     o_status
);

    localparam int PTR_W = (idvn_pkg::QDEPTH > 1) ? $clog2(idvn_pkg::QDEPTH) : 1;
    localparam int CNT_W = $clog2(idvn_pkg::QDEPTH + 1);

    logic [WIDTH-1:0] r_mem [idvn_pkg::QDEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;

    assign o_data         = r_mem[r_rp];
    assign o_status.full  = (r_cnt == CNT_W'(idvn_pkg::QDEPTH));
    assign o_status.empty = (r_cnt == '0);

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PTR_W'(idvn_pkg::QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PTR_W'(idvn_pkg::QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule
`default_nettype wire

[sv/idvn_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module idvn_back #(
    parameter int COORD_WIDTH = 32,
    parameter int OUT_FRAC_BITS = 30,
    localparam int MW = COORD_WIDTH + 1,
    localparam int ENTRY_W = 6 * MW + 6
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_q_valid,
    input  wire logic [ENTRY_W-1:0] i_q_entry,
    output logic                    o_q_pop,
    output logic                    o_res_valid,
    input  wire logic               i_res_ready,
    output idvn_pkg::t_result       o_res
);

    localparam int AW = idvn_pkg::ACC_W;
    localparam int RW = idvn_pkg::ROOT_W;
    localparam int BB = idvn_pkg::BLOCK_BITS;
    localparam int CW = idvn_pkg::CNT_W;
    localparam int CLZ_W = idvn_pkg::CLZ_W;
    localparam int NRM_LO = AW - BB;

    idvn_pkg::t_state r_state, n_state;
    idvn_pkg::t_phase r_phase, n_phase;

    logic [AW-1:0]                 r_acc [3], n_acc [3];
    logic                          r_deg, n_deg;
    logic [AW-1:0]                 r_vec [3], n_vec [3];
    logic [MW-1:0]                 r_dm [3], n_dm [3];
    logic [BB-1:0]                 r_nmn [3], n_nmn [3];
    logic [2:0]                    r_nneg, n_nneg;
    logic [2:0]                    r_sneg, n_sneg;
    logic                          r_last, n_last;
    logic [2:0]                    r_step, n_step;
    logic [idvn_pkg::CLZ_W-1:0]    r_clz, n_clz;
    logic [idvn_pkg::CLZ_W-1:0]    r_ld, n_ld;
    logic [1:0]                    r_idx, n_idx;
    logic [idvn_pkg::SQ_W-1:0]     r_sq, n_sq;
    logic [RW-1:0]                 r_res, n_res;
    logic [RW+1:0]                 r_srem, n_srem;
    logic [4:0]                    r_scnt, n_scnt;
    logic [RW-1:0]                 r_rn, n_rn;
    logic [RW-1:0]                 r_rd, n_rd;
    logic [RW-1:0]                 r_dnum, n_dnum;
    logic [RW-1:0]                 r_den, n_den;
    logic [RW-1:0]                 r_rem, n_rem;
    logic [AW-1:0]                 r_q, n_q;
    logic [CW-1:0]                 r_dcnt, n_dcnt;
    logic [idvn_pkg::OUT_W-1:0]    r_out [3], n_out [3];
    logic                          r_odeg, n_odeg;

    // scratch
    logic [AW-1:0]                 all_bits;
    logic [idvn_pkg::CLZ_W-1:0]    sh;
    logic [2*BB-1:0]               prod;
    logic [RW+3:0]                 root_rem;
    logic [RW+3:0]                 root_trial;
    logic [RW:0]                   dtrial;
    logic                          dge;
    logic [AW-1:0]                 contrib;
    logic [RW-1:0]                 sat_v;
    logic [AW-1:0]                 mag [3];
    logic                          sum_zero;
    logic [1:0]                    nxt;

    assign o_res.x          = r_out[0];
    assign o_res.y          = r_out[1];
    assign o_res.z          = r_out[2];
    assign o_res.degenerate = r_odeg;

    // sequencer over shared normalize, square-sum, root and divide units
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_deg   = r_deg;
        n_nneg  = r_nneg;
        n_sneg  = r_sneg;
        n_last  = r_last;
        n_step  = r_step;
        n_clz   = r_clz;
        n_ld    = r_ld;
        n_idx   = r_idx;
        n_sq    = r_sq;
        n_res   = r_res;
        n_srem  = r_srem;
        n_scnt  = r_scnt;
        n_rn    = r_rn;
        n_rd    = r_rd;
        n_dnum  = r_dnum;
        n_den   = r_den;
        n_rem   = r_rem;
        n_q     = r_q;
        n_dcnt  = r_dcnt;
        n_odeg  = r_odeg;
        for (int i = 0; i < 3; i++) begin
            n_acc[i] = r_acc[i];
            n_vec[i] = r_vec[i];
            n_dm[i]  = r_dm[i];
            n_nmn[i] = r_nmn[i];
            n_out[i] = r_out[i];
            mag[i]   = r_acc[i][AW-1] ? (AW'(0) - r_acc[i]) : r_acc[i];
        end
        o_q_pop     = 1'b0;
        o_res_valid = 1'b0;
        all_bits    = r_vec[0] | r_vec[1] | r_vec[2];
        sh          = 7'd32 >> r_step;
        prod        = r_vec[r_idx][AW-1:NRM_LO] * r_vec[r_idx][AW-1:NRM_LO];
        root_rem    = {r_srem, r_sq[idvn_pkg::SQ_W-1 -: 2]};
        root_trial  = {2'b00, r_res, 2'b01};
        dtrial      = {r_rem, r_dnum[RW-1]};
        dge         = dtrial >= {1'b0, r_den};
        contrib     = (r_ld > CLZ_W'(idvn_pkg::CONTRIB_EXP))
                    ? (r_q >> (r_ld - CLZ_W'(idvn_pkg::CONTRIB_EXP))) : r_q;
        sat_v       = (r_q > AW'(32'h7FFF_FFFF)) ? 31'h7FFF_FFFF : r_q[RW-1:0];
        sum_zero    = (r_acc[0] == '0) && (r_acc[1] == '0) && (r_acc[2] == '0);
        nxt         = r_idx + 2'd1;

        case (r_state)
            // take the next word from the queue
            idvn_pkg::S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_nneg  = i_q_entry[6 * MW +: 3];
                    n_last  = i_q_entry[6 * MW + 3];
                    for (int i = 0; i < 3; i++) begin
                        n_vec[i] = AW'(i_q_entry[i * MW +: MW]);
                        n_dm[i]  = i_q_entry[(3 + i) * MW +: MW];
                    end
                    n_step  = '0;
                    n_clz   = '0;
                    n_phase = idvn_pkg::P_FACE;
                    if (i_q_entry[6 * MW + 4] || i_q_entry[6 * MW + 5]) begin
                        n_deg   = 1'b1;
                        n_state = idvn_pkg::S_LAST;
                    end else begin
                        n_state = idvn_pkg::S_NORM;
                    end
                end
            end
            // leading-zero search, one binary step per cycle
            idvn_pkg::S_NORM: begin
                if ((all_bits >> (7'd64 - sh)) == '0) begin
                    for (int i = 0; i < 3; i++) begin
                        n_vec[i] = r_vec[i] << sh;
                    end
                    n_clz = r_clz + sh;
                end
                n_step = r_step + 3'd1;
                if (r_step == 3'(idvn_pkg::NORM_STEPS - 1)) begin
                    n_idx   = '0;
                    n_sq    = '0;
                    n_state = idvn_pkg::S_SQ;
                end
            end
            // sum of squares, one component per cycle
            idvn_pkg::S_SQ: begin
                n_sq  = r_sq + idvn_pkg::SQ_W'(prod);
                n_idx = nxt;
                if (r_idx == 2'd2) begin
                    n_res   = '0;
                    n_srem  = '0;
                    n_scnt  = '0;
                    n_state = idvn_pkg::S_SQRT;
                end
            end
            // integer square root, one result bit per cycle
            idvn_pkg::S_SQRT: begin
                n_sq = r_sq << 2;
                if (root_rem >= root_trial) begin
                    n_srem = (RW+2)'(root_rem - root_trial);
                    n_res  = {r_res[RW-2:0], 1'b1};
                end else begin
                    n_srem = (RW+2)'(root_rem);
                    n_res  = {r_res[RW-2:0], 1'b0};
                end
                n_scnt = r_scnt + 5'd1;
                if (r_scnt == 5'(RW - 1)) begin
                    n_state = idvn_pkg::S_ROOT;
                end
            end
            // route the length to the next step
            idvn_pkg::S_ROOT: begin
                n_idx = '0;
                n_rem = '0;
                n_q   = '0;
                case (r_phase)
                    idvn_pkg::P_FACE: begin
                        n_rn = r_res;
                        for (int i = 0; i < 3; i++) begin
                            n_nmn[i] = r_vec[i][AW-1:NRM_LO];
                            n_vec[i] = AW'(r_dm[i]);
                        end
                        n_step  = '0;
                        n_clz   = '0;
                        n_phase = idvn_pkg::P_DIST;
                        n_state = idvn_pkg::S_NORM;
                    end
                    idvn_pkg::P_DIST: begin
                        n_rd    = r_res;
                        n_ld    = CLZ_W'(AW) - r_clz;
                        n_dnum  = RW'(r_nmn[0]);
                        n_den   = r_rn;
                        n_dcnt  = CW'(RW + BB);
                        n_phase = idvn_pkg::P_FACE;
                        n_state = idvn_pkg::S_DIV;
                    end
                    default: begin
                        n_rn    = r_res;
                        n_dnum  = RW'(r_vec[0][AW-1:NRM_LO]);
                        n_den   = r_res;
                        n_dcnt  = CW'(RW + OUT_FRAC_BITS);
                        n_phase = idvn_pkg::P_SUM;
                        n_state = idvn_pkg::S_DIV;
                    end
                endcase
            end
            // restoring division, one quotient bit per cycle
            idvn_pkg::S_DIV: begin
                n_dnum = r_dnum << 1;
                n_rem  = dge ? RW'(dtrial - {1'b0, r_den}) : dtrial[RW-1:0];
                n_q    = {r_q[AW-2:0], dge};
                n_dcnt = r_dcnt - 1'b1;
                if (r_dcnt == CW'(1)) begin
                    n_state = idvn_pkg::S_DIV_DONE;
                end
            end
            // use the quotient and start the next division
            idvn_pkg::S_DIV_DONE: begin
                n_rem   = '0;
                n_q     = '0;
                n_state = idvn_pkg::S_DIV;
                case (r_phase)
                    idvn_pkg::P_FACE: begin
                        n_dnum  = r_q[RW-1:0];
                        n_den   = r_rd;
                        n_dcnt  = (r_ld > CLZ_W'(idvn_pkg::CONTRIB_EXP)) ? CW'(RW)
                                : CW'(RW + idvn_pkg::CONTRIB_EXP) - CW'(r_ld);
                        n_phase = idvn_pkg::P_CONTRIB;
                    end
                    idvn_pkg::P_CONTRIB: begin
                        for (int i = 0; i < 3; i++) begin
                            if (r_idx == 2'(i)) begin
                                n_acc[i] = r_nneg[i] ? r_acc[i] - contrib : r_acc[i] + contrib;
                            end
                        end
                        n_idx   = nxt;
                        n_dnum  = RW'(r_nmn[nxt]);
                        n_den   = r_rn;
                        n_dcnt  = CW'(RW + BB);
                        n_phase = idvn_pkg::P_FACE;
                        if (r_idx == 2'd2) begin
                            n_state = idvn_pkg::S_LAST;
                        end
                    end
                    default: begin
                        for (int i = 0; i < 3; i++) begin
                            if (r_idx == 2'(i)) begin
                                n_out[i] = r_sneg[i] ? (32'd0 - {1'b0, sat_v})
                                                     : {1'b0, sat_v};
                            end
                        end
                        n_idx  = nxt;
                        n_dnum = RW'(r_vec[nxt][AW-1:NRM_LO]);
                        n_den  = r_rn;
                        n_dcnt = CW'(RW + OUT_FRAC_BITS);
                        if (r_idx == 2'd2) begin
                            n_odeg  = 1'b0;
                            n_state = idvn_pkg::S_EMIT;
                        end
                    end
                endcase
            end
            // end of a face word: back to idle, or at a vertex end normalize the sum or flag it
            idvn_pkg::S_LAST: begin
                if (!r_last) begin
                    n_state = idvn_pkg::S_IDLE;
                end else if (r_deg || sum_zero) begin
                    for (int i = 0; i < 3; i++) begin
                        n_out[i] = '0;
                    end
                    n_odeg  = 1'b1;
                    n_state = idvn_pkg::S_EMIT;
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        n_vec[i]  = mag[i];
                        n_sneg[i] = r_acc[i][AW-1];
                    end
                    n_step  = '0;
                    n_clz   = '0;
                    n_phase = idvn_pkg::P_SUM;
                    n_state = idvn_pkg::S_NORM;
                end
            end
            // hand the result to the output register
            idvn_pkg::S_EMIT: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    for (int i = 0; i < 3; i++) begin
                        n_acc[i] = '0;
                    end
                    n_deg   = 1'b0;
                    n_state = idvn_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = idvn_pkg::S_IDLE;
            end
        endcase
    end

    // control state and accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= idvn_pkg::S_IDLE;
            r_deg   <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_acc[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_deg   <= n_deg;
            for (int i = 0; i < 3; i++) begin
                r_acc[i] <= n_acc[i];
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_phase <= n_phase;
        r_nneg  <= n_nneg;
        r_sneg  <= n_sneg;
        r_last  <= n_last;
        r_step  <= n_step;
        r_clz   <= n_clz;
        r_ld    <= n_ld;
        r_idx   <= n_idx;
        r_sq    <= n_sq;
        r_res   <= n_res;
        r_srem  <= n_srem;
        r_scnt  <= n_scnt;
        r_rn    <= n_rn;
        r_rd    <= n_rd;
        r_dnum  <= n_dnum;
        r_den   <= n_den;
        r_rem   <= n_rem;
        r_q     <= n_q;
        r_dcnt  <= n_dcnt;
        r_odeg  <= n_odeg;
        for (int i = 0; i < 3; i++) begin
            r_vec[i] <= n_vec[i];
            r_dm[i]  <= n_dm[i];
            r_nmn[i] <= n_nmn[i];
            r_out[i] <= n_out[i];
        end
    end

endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;

    localparam int CW       = 32;
    localparam int OFB      = 30;
    localparam int IN_BITS  = 9 * CW;
    localparam int LIMIT    = 12_000_000;
    localparam int N_RANDOM = 1450;

    typedef struct {
        logic [CW-1:0] vert [3];
        logic [CW-1:0] cent [3];
        logic [CW-1:0] anrm [3];
        logic          last;
    } t_face_word;

    typedef struct {
        logic [31:0] nx;
        logic [31:0] ny;
        logic [31:0] nz;
        logic        degen;
    } t_normal_word;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [IN_BITS-1:0]  s_tdata;
    logic                s_tlast;
    logic                m_tvalid;
    logic                m_tready;
    logic [95:0]         m_tdata;
    logic                m_tuser;

    t_face_word   pending_faces[$];
    t_normal_word expected_normals[$];
    int           fail_count;
    int           cycle_count;
    bit           stim_done;
    bit           quiet_mode;
    int           src_gap;
    int           sink_gap;

    // vertex accumulator copy
    logic [63:0] acc_x, acc_y, acc_z;
    bit          acc_degen;

    inverse_distance_vertex_normal_core #(
        .COORD_WIDTH(CW),
        .OUT_FRAC_BITS(OFB)
    ) DUT (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata),
        .i_s_axis_tlast(s_tlast),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata(m_tdata),
        .o_m_axis_tuser(m_tuser)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // shift so the largest magnitude lies in [2^29, 2^30), returns bit length
    function automatic int block_shift(inout logic [63:0] m [3]);
        logic [63:0] all;
        int len;
        all = m[0] | m[1] | m[2];
        len = 0;
        while (len < 64 && (all >> len) != 0) len++;
        if (len == 0) return 0;
        for (int i = 0; i < 3; i++) begin
            if (len > idvn_pkg::BLOCK_BITS) m[i] = m[i] >> (len - idvn_pkg::BLOCK_BITS);
            else m[i] = m[i] << (idvn_pkg::BLOCK_BITS - len);
        end
        return len;
    endfunction

    function automatic logic [63:0] root_floor(logic [63:0] x);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] vec_length(logic [63:0] m [3]);
        return root_floor(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
    endfunction

    // floor(num * 2^e / den) by restoring division
    function automatic logic [63:0] scaled_quot(logic [63:0] num, logic [63:0] den, int e);
        logic [63:0] q, r;
        q = num / den;
        r = num % den;
        if (e < 0) return (-e >= 64) ? 64'd0 : (q >> (-e));
        for (int k = 0; k < e; k++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
                r = r - den;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    // fold one face into the vertex sum, queue a normal on the last face
    task automatic predict_normal(input t_face_word w);
        logic [63:0] nm [3];
        logic [63:0] dm [3];
        logic [63:0] sm [3];
        logic [63:0] rn, rd, rs, u, c, v, diff;
        logic [63:0] acc [3];
        bit nneg [3];
        bit sneg [3];
        int ln, ld, ls;
        t_normal_word r;
        acc[0] = acc_x; acc[1] = acc_y; acc[2] = acc_z;
        for (int i = 0; i < 3; i++) begin
            nneg[i] = w.anrm[i][CW-1];
            nm[i] = nneg[i] ? -64'($signed(w.anrm[i])) : 64'($signed(w.anrm[i]));
            diff = 64'($signed(w.vert[i])) - 64'($signed(w.cent[i]));
            dm[i] = diff[63] ? -diff : diff;
        end
        ln = block_shift(nm);
        ld = block_shift(dm);
        if (ln == 0 || ld == 0) begin
            acc_degen = 1'b1;
        end else begin
            rn = vec_length(nm);
            rd = vec_length(dm);
            for (int i = 0; i < 3; i++) begin
                u = scaled_quot(nm[i], rn, 30);
                c = scaled_quot(u, rd, idvn_pkg::CONTRIB_EXP - ld);
                acc[i] = nneg[i] ? acc[i] - c : acc[i] + c;
            end
        end
        acc_x = acc[0]; acc_y = acc[1]; acc_z = acc[2];
        if (!w.last) return;
        for (int i = 0; i < 3; i++) begin
            sneg[i] = acc[i][63];
            sm[i] = sneg[i] ? -acc[i] : acc[i];
        end
        ls = block_shift(sm);
        if (acc_degen || ls == 0) begin
            r = '{nx: 0, ny: 0, nz: 0, degen: 1'b1};
        end else begin
            rs = vec_length(sm);
            for (int i = 0; i < 3; i++) begin
                v = scaled_quot(sm[i], rs, OFB);
                if (v > 64'h7FFF_FFFF) v = 64'h7FFF_FFFF;
                sm[i] = sneg[i] ? -v : v;
            end
            r = '{nx: sm[0][31:0], ny: sm[1][31:0], nz: sm[2][31:0], degen: 1'b0};
        end
        expected_normals.push_back(r);
        acc_x = 0; acc_y = 0; acc_z = 0;
        acc_degen = 1'b0;
    endtask

    function automatic logic [CW-1:0] rand_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return CW'($signed($urandom_range(0, 2000)) - 1000) << 16;
            2: return CW'($signed($urandom_range(0, 64)) - 32);
            default: return $urandom & 32'h00FF_FFFF;
        endcase
    endfunction

    function automatic t_face_word rand_face(bit last);
        t_face_word w;
        int mode;
        mode = $urandom_range(0, 3);
        for (int i = 0; i < 3; i++) begin
            w.vert[i] = rand_coord(mode);
            w.cent[i] = rand_coord(mode);
            w.anrm[i] = rand_coord($urandom_range(0, 3));
        end
        // occasional degenerate faces
        if ($urandom_range(0, 30) == 0) w.cent = w.vert;
        if ($urandom_range(0, 30) == 0) w.anrm = '{0, 0, 0};
        w.last = last;
        return w;
    endfunction

    function automatic t_face_word make_face(logic [CW-1:0] v, logic [CW-1:0] c,
                                             logic [CW-1:0] n, bit last);
        t_face_word w;
        w.vert = '{v, v, v};
        w.cent = '{c, c, c};
        w.anrm = '{n, n, n};
        w.last = last;
        return w;
    endfunction

    // stimulus
    initial begin
        t_face_word w;
        int faces;
        stim_done = 0;
        quiet_mode = 0;
        // directed: extremes, degenerate cases, cancelling sums
        pending_faces.push_back(make_face(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1));
        pending_faces.push_back(make_face(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1));
        pending_faces.push_back(make_face(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1));
        pending_faces.push_back(make_face(32'h0001_0000, 0, 0, 1));
        pending_faces.push_back(make_face(0, 32'hFFFF_FFFF, 32'h0000_0001, 1));
        pending_faces.push_back(make_face(0, 32'h0001_0000, 32'h0001_0000, 0));
        pending_faces.push_back(make_face(0, 32'h0001_0000, 32'hFFFF_0000, 1));
        pending_faces.push_back(make_face(0, 32'h0000_0001, 32'h0000_0001, 0));
        pending_faces.push_back(make_face(5, 5, 32'h0000_0001, 0));
        pending_faces.push_back(make_face(32'h1234_5678, 32'hEDCB_A988, 32'h5555_5555, 1));
        w = make_face(0, 32'h0002_0000, 0, 1);
        w.anrm[2] = 32'h0001_0000;
        w.vert[0] = 32'hFFFF_8000;
        pending_faces.push_back(w);
        w = make_face(32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF, 0);
        pending_faces.push_back(w);
        w.last = 1;
        pending_faces.push_back(w);
        pending_faces.push_back(make_face(32'h7FFF_FFFF, 32'h7FFF_FFFE, 32'h8000_0000, 1));
        // random vertex fans of 1 to 8 faces
        faces = 0;
        while (faces < N_RANDOM) begin
            int fan;
            fan = $urandom_range(1, 8);
            for (int k = 0; k < fan; k++) begin
                pending_faces.push_back(rand_face(k == fan - 1));
                faces++;
            end
        end
        wait (pending_faces.size() < 100);
        quiet_mode = 1;
        wait (pending_faces.size() == 0 && !s_tvalid);
        stim_done = 1;
    end

    // source side
    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
            src_gap  <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) predict_normal(pending_faces.pop_front());
            if (src_gap > 0) begin
                src_gap  <= src_gap - 1;
                s_tvalid <= 1'b0;
            end else if (!quiet_mode && $urandom_range(0, 9) == 0) begin
                src_gap  <= $urandom_range(1, 12);
                s_tvalid <= 1'b0;
            end else if (pending_faces.size() > 0) begin
                t_face_word w;
                w = pending_faces[0];
                s_tvalid <= 1'b1;
                s_tdata  <= {w.anrm[2], w.anrm[1], w.anrm[0], w.cent[2], w.cent[1],
                             w.cent[0], w.vert[2], w.vert[1], w.vert[0]};
                s_tlast  <= w.last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // the current face word leaves the queue only when accepted; the driver
    // always presents the queue head, so the pop above matches the handshake

    // sink side and checking
    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
            sink_gap <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                t_normal_word e;
                if (expected_normals.size() == 0) begin
                    $error("unexpected normal word %h tuser %b", m_tdata, m_tuser);
                    fail_count++;
                end else begin
                    e = expected_normals.pop_front();
                    if (m_tdata[31:0] !== e.nx) begin
                        $error("unit_normal_x exp %h got %h", e.nx, m_tdata[31:0]);
                        fail_count++;
                    end
                    if (m_tdata[63:32] !== e.ny) begin
                        $error("unit_normal_y exp %h got %h", e.ny, m_tdata[63:32]);
                        fail_count++;
                    end
                    if (m_tdata[95:64] !== e.nz) begin
                        $error("unit_normal_z exp %h got %h", e.nz, m_tdata[95:64]);
                        fail_count++;
                    end
                    if (m_tuser !== e.degen) begin
                        $error("degenerate exp %b got %b", e.degen, m_tuser);
                        fail_count++;
                    end
                end
            end
            if (sink_gap > 0) begin
                sink_gap <= sink_gap - 1;
                m_tready <= 1'b0;
            end else if (!quiet_mode && $urandom_range(0, 9) == 0) begin
                sink_gap <= $urandom_range(1, 12);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // reset, watchdog and end of run
    initial begin
        fail_count  = 0;
        cycle_count = 0;
        acc_x = 0; acc_y = 0; acc_z = 0;
        acc_degen = 0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        m_tready = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        while (!(stim_done && expected_normals.size() == 0) && cycle_count < LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        if (cycle_count >= LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            repeat (600) @(posedge clk);
            if (fail_count == 0 && expected_normals.size() == 0) begin
                $display("SUCCESS");
            end else begin
                $display("FAILURE");
            end
            $finish;
        end
    end

endmodule

[filelist.f]
sv/idvn_pkg.sv
sv/idvn_front.sv
sv/idvn_queue.sv
sv/idvn_back.sv
sv/inverse_distance_vertex_normal_core.sv
tb/sv/tb_top.sv
